[rtl/core/mpps_pkg.sv]
// Package with the shared types and codes of the job scheduler.
`timescale 1ns / 1ps
`default_nettype none
package mpps_pkg;

  localparam logic [2:0] POL_NONE = 3'd0;
  localparam logic [2:0] POL_FCFS = 3'd1;
  localparam logic [2:0] POL_RR   = 3'd2;
  localparam logic [2:0] POL_SJF  = 3'd3;
  localparam logic [2:0] POL_AGE  = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOPOL  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_IDLE   = 2'd3;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_SLICE  = 1'b1;

  localparam logic [3:0] DEFAULT_SLICE = 4'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_SHIFT,
    S_AGE,
    S_CHECK,
    S_OUT
  } state_e;

endpackage
`default_nettype wire

[rtl/core/mpps_queue.sv]
// Waiting queue register file with a single read port and a single write port.
`timescale 1ns / 1ps
`default_nettype none
module mpps_queue import mpps_pkg::*; #(
  parameter int QUEUE_DEPTH = 4,
  parameter int ID_BITS     = 8,
  parameter int LENGTH_BITS = 10,
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  wire                    clk_i,
  input  wire  [IW-1:0]          rd_idx_i,
  output logic [ID_BITS-1:0]     rd_id_o,
  output logic [LENGTH_BITS-1:0] rd_line_o,
  output logic [LENGTH_BITS-1:0] rd_len_o,
  output logic [LENGTH_BITS-1:0] rd_rank_o,
  input  wire                    we_i,
  input  wire  [IW-1:0]          wr_idx_i,
  input  wire  [ID_BITS-1:0]     wr_id_i,
  input  wire  [LENGTH_BITS-1:0] wr_line_i,
  input  wire  [LENGTH_BITS-1:0] wr_len_i,
  input  wire  [LENGTH_BITS-1:0] wr_rank_i
);

  logic [ID_BITS-1:0]     id_q   [QUEUE_DEPTH];
  logic [LENGTH_BITS-1:0] line_q [QUEUE_DEPTH];
  logic [LENGTH_BITS-1:0] len_q  [QUEUE_DEPTH];
  logic [LENGTH_BITS-1:0] rank_q [QUEUE_DEPTH];

  assign rd_id_o   = id_q[rd_idx_i];
  assign rd_line_o = line_q[rd_idx_i];
  assign rd_len_o  = len_q[rd_idx_i];
  assign rd_rank_o = rank_q[rd_idx_i];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      id_q[wr_idx_i]   <= wr_id_i;
      line_q[wr_idx_i] <= wr_line_i;
      len_q[wr_idx_i]  <= wr_len_i;
      rank_q[wr_idx_i] <= wr_rank_i;
    end
  end

endmodule
`default_nettype wire

[rtl/core/multi_policy_process_scheduler.sv]
// Top level of the multi-policy job scheduler.
// The input channel (in_valid_i/in_ready_o) carries one beat per command:
// func 0 adds a job, func 1 is a scheduler tick that runs one line.
// Each command beat yields exactly one result beat on the output channel
// (out_valid_o/out_ready_i) with a status and the tick outcome.
// Configuration writes use cfg_valid_i/cfg_ready_o with an index and data:
// index 0 is the policy, index 1 the round robin slice length.
// A command walks the waiting queue one entry per cycle through a single
// read port and a single write port. The longest command is an aging tick
// that pops the head, shifts the queue down, ages every entry and then
// requeues a preempted job in rank order. One command is in flight at a
// time. The block is ready again in the cycle after the result beat is
// taken. If the receiver stalls, the result is held and no command is taken.
// Reset clears the queue count, running job and registers; the queue
// entries themselves are not cleared, as only filled entries are read.
`timescale 1ns / 1ps
`default_nettype none
module multi_policy_process_scheduler import mpps_pkg::*; #(
  parameter int QUEUE_DEPTH = 4,
  parameter int ID_BITS     = 8,
  parameter int LENGTH_BITS = 10
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire                    cfg_index_i,
  input  wire  [3:0]             cfg_data_i,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire                    func_i,
  input  wire  [ID_BITS-1:0]     job_id_i,
  input  wire  [LENGTH_BITS-1:0] job_length_i,
  input  wire                    fetch_fault_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output logic [1:0]             status_o,
  output logic                   ran_valid_o,
  output logic [ID_BITS-1:0]     ran_id_o,
  output logic [LENGTH_BITS-1:0] ran_line_o,
  output logic                   finished_o,
  output logic                   faulted_o,
  output logic                   preempted_o,
  output logic                   all_done_o
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  state_e state_q, state_d;

  logic [2:0] pol_q;
  logic [3:0] slice_len_q;
  logic [CW-1:0] wcnt_q, wcnt_d, live_q, live_d;
  logic run_v_q, run_v_d;
  logic [ID_BITS-1:0] run_id_q, run_id_d;
  logic [LENGTH_BITS-1:0] run_line_q, run_line_d, run_len_q, run_len_d;
  logic [LENGTH_BITS-1:0] run_rank_q, run_rank_d;
  logic [3:0] slc_q, slc_d;

  // Pending insert job and walk pointers.
  logic [ID_BITS-1:0] ins_id_q, ins_id_d;
  logic [LENGTH_BITS-1:0] ins_line_q, ins_line_d, ins_len_q, ins_len_d;
  logic [LENGTH_BITS-1:0] ins_rank_q, ins_rank_d;
  logic [CW-1:0] ptr_q, ptr_d, pos_q, pos_d;
  logic shift_dn_q, shift_dn_d;   // 1: shifting toward head (pop)
  logic after_ins_q, after_ins_d; // requeue done, continue to aging/out
  logic chk_done_q, chk_done_d;

  logic [1:0] st_q, st_d;
  logic rv_q, rv_d, fin_q, fin_d, flt_q, flt_d, pre_q, pre_d, ad_q, ad_d;
  logic [ID_BITS-1:0] rid_q, rid_d;
  logic [LENGTH_BITS-1:0] rline_q, rline_d;

  logic [IW-1:0] rd_idx, wr_idx;
  logic we;
  logic [ID_BITS-1:0] rd_id, wr_id;
  logic [LENGTH_BITS-1:0] rd_line, rd_len, rd_rank, wr_line, wr_len, wr_rank;

  mpps_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS),
               .LENGTH_BITS(LENGTH_BITS)) u_queue (
    .clk_i, .rd_idx_i(rd_idx), .rd_id_o(rd_id), .rd_line_o(rd_line),
    .rd_len_o(rd_len), .rd_rank_o(rd_rank), .we_i(we), .wr_idx_i(wr_idx),
    .wr_id_i(wr_id), .wr_line_i(wr_line), .wr_len_i(wr_len), .wr_rank_i(wr_rank)
  );

  logic pol_ok, sorted;
  assign pol_ok = (pol_q >= POL_FCFS) && (pol_q <= POL_AGE);
  assign sorted = (pol_q == POL_SJF) || (pol_q == POL_AGE);

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign status_o    = st_q;
  assign ran_valid_o = rv_q;
  assign ran_id_o    = rid_q;
  assign ran_line_o  = rline_q;
  assign finished_o  = fin_q;
  assign faulted_o   = flt_q;
  assign preempted_o = pre_q;
  assign all_done_o  = ad_q;

  // Sequencer: next state plus datapath updates.
  always_comb begin
    logic [LENGTH_BITS-1:0] nl;
    logic [3:0] lim;
    state_d = state_q;
    wcnt_d = wcnt_q; live_d = live_q;
    run_v_d = run_v_q; run_id_d = run_id_q; run_line_d = run_line_q;
    run_len_d = run_len_q; run_rank_d = run_rank_q; slc_d = slc_q;
    ins_id_d = ins_id_q; ins_line_d = ins_line_q; ins_len_d = ins_len_q;
    ins_rank_d = ins_rank_q; ptr_d = ptr_q; pos_d = pos_q;
    shift_dn_d = shift_dn_q; after_ins_d = after_ins_q; chk_done_d = chk_done_q;
    st_d = st_q; rv_d = rv_q; fin_d = fin_q; flt_d = flt_q; pre_d = pre_q;
    ad_d = ad_q; rid_d = rid_q; rline_d = rline_q;
    rd_idx = ptr_q[IW-1:0];
    we = 1'b0; wr_idx = ptr_q[IW-1:0];
    wr_id = ins_id_q; wr_line = ins_line_q; wr_len = ins_len_q; wr_rank = ins_rank_q;
    nl = '0;
    lim = (slice_len_q == 4'd0) ? 4'd1 : slice_len_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          st_d = ST_OK; rv_d = 1'b0; fin_d = 1'b0; flt_d = 1'b0; pre_d = 1'b0;
          ad_d = 1'b0; rid_d = '0; rline_d = '0;
          after_ins_d = 1'b0; chk_done_d = 1'b0;
          if (!pol_ok) begin
            st_d = ST_NOPOL; state_d = S_OUT;
          end else if (!func_i) begin
            if (live_q >= DEPTH_C) begin
              st_d = ST_FULL; state_d = S_OUT;
            end else begin
              ins_id_d = job_id_i; ins_line_d = '0; ins_len_d = job_length_i;
              ins_rank_d = job_length_i; live_d = live_q + 1'b1;
              ptr_d = '0; pos_d = wcnt_q; state_d = S_SCAN;
              after_ins_d = 1'b0; chk_done_d = 1'b1;
            end
          end else if (!run_v_q && wcnt_q == '0) begin
            st_d = ST_IDLE; state_d = S_OUT;
          end else begin
            flt_d = fetch_fault_i;
            if (!run_v_q) begin
              // Pop head into running slot, then shift queue down.
              ptr_d = '0; state_d = S_PREP;
            end else begin
              state_d = S_PREP; ptr_d = DEPTH_C; // marker: no pop
            end
          end
        end
      end
      S_PREP: begin
        // Pop when requested, then execute the line.
        if (ptr_q == '0) begin
          run_id_d = rd_id; run_line_d = rd_line; run_len_d = rd_len;
          run_rank_d = rd_rank; run_v_d = 1'b1; slc_d = '0;
          wcnt_d = wcnt_q - 1'b1; ptr_d = CW'(1);
          shift_dn_d = 1'b1; state_d = S_SHIFT;
        end else begin
          rid_d = run_id_q; rline_d = run_line_q;
          chk_done_d = 1'b0;
          if (flt_q) begin
            ins_id_d = run_id_q; ins_line_d = run_line_q; ins_len_d = run_len_q;
            ins_rank_d = run_rank_q; run_v_d = 1'b0; slc_d = '0;
            ptr_d = '0; pos_d = wcnt_q; after_ins_d = 1'b1; state_d = S_SCAN;
          end else begin
            rv_d = 1'b1;
            nl = run_line_q + 1'b1;
            run_line_d = nl;
            slc_d = slc_q + 1'b1;
            if (nl >= run_len_q) begin
              fin_d = 1'b1; run_v_d = 1'b0; slc_d = '0;
              if (live_q != '0) live_d = live_q - 1'b1;
              if (live_q <= CW'(1)) ad_d = 1'b1;
              state_d = (pol_q == POL_AGE) ? S_AGE : S_OUT;
              ptr_d = '0;
            end else if (pol_q == POL_RR && (slc_q + 1'b1) >= lim) begin
              pre_d = 1'b1;
              ins_id_d = run_id_q; ins_line_d = nl; ins_len_d = run_len_q;
              ins_rank_d = run_rank_q; run_v_d = 1'b0; slc_d = '0;
              ptr_d = '0; pos_d = wcnt_q; after_ins_d = 1'b1; chk_done_d = 1'b1;
              state_d = S_SCAN;
            end else begin
              state_d = (pol_q == POL_AGE) ? S_AGE : S_OUT;
              ptr_d = '0;
            end
          end
        end
      end
      S_SHIFT: begin
        if (shift_dn_q) begin
          // Move entry ptr to ptr-1 for all ptr < old count.
          if (ptr_q <= wcnt_q) begin
            rd_idx = ptr_q[IW-1:0];
            we = 1'b1; wr_idx = IW'(ptr_q - 1'b1);
            wr_id = rd_id; wr_line = rd_line; wr_len = rd_len; wr_rank = rd_rank;
            ptr_d = ptr_q + 1'b1;
          end else begin
            ptr_d = DEPTH_C; state_d = S_PREP;
          end
        end else begin
          // Open a hole at pos by moving entries up, from the back.
          if (ptr_q > pos_q) begin
            rd_idx = IW'(ptr_q - 1'b1);
            we = 1'b1; wr_idx = ptr_q[IW-1:0];
            wr_id = rd_id; wr_line = rd_line; wr_len = rd_len; wr_rank = rd_rank;
            ptr_d = ptr_q - 1'b1;
          end else begin
            we = 1'b1; wr_idx = pos_q[IW-1:0];
            wcnt_d = wcnt_q + 1'b1;
            ptr_d = '0;
            if (after_ins_q && !chk_done_q && pol_q == POL_AGE) state_d = S_AGE;
            else if (after_ins_q && pol_q == POL_AGE && !pre_q) state_d = S_AGE;
            else state_d = S_OUT;
          end
        end
      end
      S_SCAN: begin
        // Find first waiting entry with rank greater than the new rank.
        if (sorted && ptr_q < wcnt_q && ptr_q < pos_q) begin
          if (rd_rank > ins_rank_q) pos_d = ptr_q;
          ptr_d = ptr_q + 1'b1;
        end else begin
          ptr_d = wcnt_q; shift_dn_d = 1'b0; state_d = S_SHIFT;
        end
      end
      S_AGE: begin
        if (ptr_q < wcnt_q) begin
          we = 1'b1; wr_idx = ptr_q[IW-1:0];
          wr_id = rd_id; wr_line = rd_line; wr_len = rd_len;
          wr_rank = (rd_rank != '0) ? rd_rank - 1'b1 : rd_rank;
          ptr_d = ptr_q + 1'b1;
        end else begin
          ptr_d = '0;
          state_d = (flt_q) ? S_OUT : S_CHECK;
        end
      end
      S_CHECK: begin
        rd_idx = '0;
        if (run_v_q && live_q > CW'(1) && wcnt_q != '0 && rd_rank < run_rank_q) begin
          pre_d = 1'b1;
          ins_id_d = run_id_q; ins_line_d = run_line_q; ins_len_d = run_len_q;
          ins_rank_d = run_rank_q; run_v_d = 1'b0; slc_d = '0;
          ptr_d = '0; pos_d = wcnt_q; after_ins_d = 1'b1; chk_done_d = 1'b1;
          state_d = S_SCAN;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pol_q <= POL_NONE; slice_len_q <= DEFAULT_SLICE;
      wcnt_q <= '0; live_q <= '0; run_v_q <= 1'b0;
      run_id_q <= '0; run_line_q <= '0; run_len_q <= '0; run_rank_q <= '0;
      slc_q <= '0;
      ptr_q <= '0; pos_q <= '0; shift_dn_q <= 1'b0; after_ins_q <= 1'b0;
      chk_done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wcnt_q <= wcnt_d; live_q <= live_d; run_v_q <= run_v_d;
      run_id_q <= run_id_d; run_line_q <= run_line_d; run_len_q <= run_len_d;
      run_rank_q <= run_rank_d; slc_q <= slc_d;
      ptr_q <= ptr_d; pos_q <= pos_d; shift_dn_q <= shift_dn_d;
      after_ins_q <= after_ins_d; chk_done_q <= chk_done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_POLICY) begin
          if (cfg_data_i[2:0] != pol_q && live_q == '0) pol_q <= cfg_data_i[2:0];
        end else begin
          slice_len_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ins_id_q <= ins_id_d; ins_line_q <= ins_line_d; ins_len_q <= ins_len_d;
    ins_rank_q <= ins_rank_d;
    st_q <= st_d; rv_q <= rv_d; fin_q <= fin_d; flt_q <= flt_d; pre_q <= pre_d;
    ad_q <= ad_d; rid_q <= rid_d; rline_q <= rline_d;
  end

endmodule
`default_nettype wire

[verif/multi_policy_process_scheduler_tb.sv]
// Self-checking testbench of the multi-policy job scheduler.
`timescale 1ns / 1ps
`default_nettype none
module multi_policy_process_scheduler_tb;
  import mpps_pkg::*;

  // Command codes carried on the func field of an input beat.
  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam int SLOTS = 4;
  localparam int SETTLE_CYCLES = 30;

  // One result beat, in the order of the output ports.
  typedef struct packed {
    logic [1:0] status;
    logic       ran_valid;
    logic [7:0] ran_id;
    logic [9:0] ran_line;
    logic       finished;
    logic       faulted;
    logic       preempted;
    logic       all_done;
  } sched_result_t;

  // The scoreboard keeps its own copy of the scheduler: the queue, the running
  // job and both registers. Every accepted command beat advances that copy and
  // leaves the expected result beat in a FIFO; result beats are then checked
  // against the oldest entry.
  class sched_scoreboard;
    logic [2:0] policy;
    logic [3:0] slice;
    logic [7:0] q_id [SLOTS];
    logic [9:0] q_line [SLOTS];
    logic [9:0] q_len [SLOTS];
    logic [9:0] q_rank [SLOTS];
    int         q_count;
    bit         run_on;
    logic [7:0] run_id;
    logic [9:0] run_line;
    logic [9:0] run_len;
    logic [9:0] run_rank;
    logic [3:0] slice_cnt;
    int         live;
    sched_result_t expected_q[$];
    int         mismatches;
    int         checked;

    function new();
      policy = POL_NONE;
      slice = DEFAULT_SLICE;
      q_count = 0;
      run_on = 0;
      run_id = '0;
      run_line = '0;
      run_len = '0;
      run_rank = '0;
      slice_cnt = '0;
      live = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    // A policy change only takes effect while no job is alive.
    function void write_reg(logic idx, logic [3:0] data);
      if (idx == CFG_POLICY) begin
        if (data[2:0] != policy && live == 0) policy = data[2:0];
      end else begin
        slice = data;
      end
    endfunction

    function bit policy_active();
      return policy >= POL_FCFS && policy <= POL_AGE;
    endfunction

    // Sorted policies place a job after every entry of equal or lower rank.
    function void enqueue(logic [7:0] id, logic [9:0] line, logic [9:0] len,
                          logic [9:0] rank);
      int pos;
      pos = q_count;
      if (policy == POL_SJF || policy == POL_AGE) begin
        for (int i = 0; i < q_count; i++) begin
          if (q_rank[i] > rank) begin
            pos = i;
            break;
          end
        end
      end
      if (q_count >= SLOTS) return;
      for (int i = q_count; i > pos; i--) begin
        q_id[i] = q_id[i-1];
        q_line[i] = q_line[i-1];
        q_len[i] = q_len[i-1];
        q_rank[i] = q_rank[i-1];
      end
      q_id[pos] = id;
      q_line[pos] = line;
      q_len[pos] = len;
      q_rank[pos] = rank;
      q_count++;
    endfunction

    function void requeue_running();
      enqueue(run_id, run_line, run_len, run_rank);
      run_on = 0;
      slice_cnt = '0;
    endfunction

    function void note_input(logic f, logic [7:0] id, logic [9:0] len, logic fault);
      sched_result_t r;
      logic [3:0] lim;
      r = '0;
      if (!policy_active()) begin
        r.status = ST_NOPOL;
      end else if (f == FUNC_ADD) begin
        if (live >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          enqueue(id, '0, len, len);
          live++;
        end
      end else if (!run_on && q_count == 0) begin
        r.status = ST_IDLE;
      end else begin
        if (!run_on) begin
          run_id = q_id[0];
          run_line = q_line[0];
          run_len = q_len[0];
          run_rank = q_rank[0];
          run_on = 1;
          slice_cnt = '0;
          for (int i = 1; i < q_count; i++) begin
            q_id[i-1] = q_id[i];
            q_line[i-1] = q_line[i];
            q_len[i-1] = q_len[i];
            q_rank[i-1] = q_rank[i];
          end
          q_count--;
        end
        r.ran_id = run_id;
        r.ran_line = run_line;
        if (fault) begin
          r.faulted = 1'b1;
          requeue_running();
        end else begin
          r.ran_valid = 1'b1;
          run_line = run_line + 10'd1;
          slice_cnt = slice_cnt + 4'd1;
          if (run_line >= run_len) begin
            r.finished = 1'b1;
            run_on = 0;
            slice_cnt = '0;
            if (live > 0) live--;
            if (live == 0) r.all_done = 1'b1;
          end
        end
        if (policy == POL_RR && run_on) begin
          lim = (slice == 4'd0) ? 4'd1 : slice;
          if (slice_cnt >= lim) begin
            r.preempted = 1'b1;
            requeue_running();
          end
        end else if (policy == POL_AGE) begin
          // Aging also touches a job that was just requeued by a fault.
          for (int i = 0; i < q_count; i++)
            if (q_rank[i] > 10'd0) q_rank[i] = q_rank[i] - 10'd1;
          if (run_on && live > 1 && q_count > 0 && q_rank[0] < run_rank) begin
            r.preempted = 1'b1;
            requeue_running();
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(sched_result_t act);
      sched_result_t exp;
      bit bad;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing expected: %p", $realtime, act);
        return;
      end
      exp = expected_q[0];
      expected_q.delete(0);
      bad = (act.status != exp.status) || (act.ran_valid != exp.ran_valid) ||
            (act.ran_id != exp.ran_id) || (act.ran_line != exp.ran_line) ||
            (act.finished != exp.finished) || (act.faulted != exp.faulted) ||
            (act.preempted != exp.preempted) || (act.all_done != exp.all_done);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result mismatch, expected %p, got %p", $realtime, exp, act);
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [3:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic       func;
  logic [7:0] job_id;
  logic [9:0] job_length;
  logic       fetch_fault;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] status;
  logic       ran_valid;
  logic [7:0] ran_id;
  logic [9:0] ran_line;
  logic       finished;
  logic       faulted;
  logic       preempted;
  logic       all_done;

  sched_scoreboard sb;
  bit steady;       // When set, neither side idles.
  int stall_left;
  int n_items;
  int n_adds;
  int n_ticks;
  int n_settings;

  multi_policy_process_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (func),
    .job_id_i      (job_id),
    .job_length_i  (job_length),
    .fetch_fault_i (fetch_fault),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .ran_valid_o   (ran_valid),
    .ran_id_o      (ran_id),
    .ran_line_o    (ran_line),
    .finished_o    (finished),
    .faulted_o     (faulted),
    .preempted_o   (preempted),
    .all_done_o    (all_done)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // The receiver stalls at random; stalls start and end at the falling edge.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!steady && $urandom_range(0, 9) < 3) stall_left = pick_gap();
    end
  end

  // Every result beat is checked at the edge where it is taken.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready)
      sb.check_result('{status, ran_valid, ran_id, ran_line,
                        finished, faulted, preempted, all_done});
  end

  // Drives one command beat and notes it in the scoreboard once it is taken.
  // With no gap the next beat follows without valid dropping in between.
  task automatic send_cmd(input logic f, input logic [7:0] id, input logic [9:0] len,
                          input logic fault);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    func <= f;
    job_id <= id;
    job_length <= len;
    fetch_fault <= fault;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sb.note_input(f, id, len, fault);
    n_items++;
    if (f == FUNC_ADD) n_adds++;
    else n_ticks++;
  endtask

  task automatic add_job(input logic [7:0] id, input logic [9:0] len);
    send_cmd(FUNC_ADD, id, len, 1'b0);
  endtask

  task automatic tick(input logic fault);
    send_cmd(FUNC_TICK, 8'($urandom), 10'($urandom), fault);
  endtask

  // Waits until every result beat has come back, then lets the block settle.
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register writes are only issued while the block is idle.
  task automatic write_reg(input logic idx, input logic [3:0] data);
    settle();
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == CFG_POLICY) n_settings++;
  endtask

  // Ticks until no job is alive so that the policy may change again.
  task automatic drain();
    while (sb.live != 0) tick($urandom_range(0, 9) == 0);
  endtask

  // Lengths stay short so that draining does not dominate the beat count.
  function automatic logic [9:0] rand_length();
    if ($urandom_range(0, 99) < 2) return 10'($urandom_range(13, 63));
    return 10'($urandom_range(0, 12));
  endfunction

  initial begin
    logic [2:0] pol;
    int phase_len;
    sb = new();
    rst_ni = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_POLICY;
    cfg_data = '0;
    in_valid = 1'b0;
    func = FUNC_ADD;
    job_id = '0;
    job_length = '0;
    fetch_fault = 1'b0;
    out_ready = 1'b0;
    steady = 1'b0;
    stall_left = 0;
    n_items = 0;
    n_adds = 0;
    n_ticks = 0;
    n_settings = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed part. No policy is selected after reset, so both commands
    // are refused; an out-of-range policy code behaves the same way.
    add_job(8'h5A, 10'd3);
    tick(1'b0);
    write_reg(CFG_POLICY, 4'b1111);
    add_job(8'hA5, 10'd4);
    write_reg(CFG_POLICY, 4'b1101);
    tick(1'b1);

    // First come first served with a zero slice register, an idle tick, the
    // id extremes, a full queue and a policy write that must be ignored.
    write_reg(CFG_SLICE, 4'd0);
    write_reg(CFG_POLICY, {1'b0, POL_FCFS});
    tick(1'b0);
    add_job(8'h00, 10'd0);
    add_job(8'hFF, 10'd40);
    add_job(8'h01, 10'd1);
    add_job(8'h02, 10'd5);
    add_job(8'h03, 10'd2);
    write_reg(CFG_POLICY, {1'b0, POL_RR});
    tick(1'b1);
    tick(1'b0);
    tick(1'b1);
    drain();

    // Round robin with the upper data bit set, then the longest slice.
    write_reg(CFG_POLICY, {1'b1, POL_RR});
    add_job(8'h10, 10'd3);
    add_job(8'h11, 10'd2);
    tick(1'b0);
    tick(1'b1);
    drain();
    write_reg(CFG_SLICE, 4'd15);

    // Shortest job first with equal ranks, then aging with a fault.
    write_reg(CFG_POLICY, {1'b0, POL_SJF});
    add_job(8'h20, 10'd9);
    add_job(8'h21, 10'd4);
    add_job(8'h22, 10'd4);
    add_job(8'h23, 10'd0);
    drain();
    write_reg(CFG_POLICY, {1'b0, POL_AGE});
    add_job(8'h30, 10'd10);
    tick(1'b0);
    add_job(8'h31, 10'd3);
    add_job(8'h32, 10'd7);
    tick(1'b1);
    tick(1'b0);
    drain();

    // Random part: phases under random settings. Each phase mixes adds and
    // ticks, tries a policy write in the middle, and drains at the end.
    while (n_items < 1050) begin
      case ($urandom_range(0, 9))
        0: pol = POL_NONE;
        1: pol = 3'($urandom_range(5, 7));
        2, 3: pol = POL_FCFS;
        4, 5: pol = POL_RR;
        6, 7: pol = POL_SJF;
        default: pol = POL_AGE;
      endcase
      write_reg(CFG_POLICY, {1'($urandom), pol});
      case ($urandom_range(0, 4))
        0: write_reg(CFG_SLICE, 4'd0);
        1: write_reg(CFG_SLICE, 4'd15);
        default: write_reg(CFG_SLICE, 4'($urandom));
      endcase
      steady = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 60);
      for (int i = 0; i < phase_len; i++) begin
        if (i == phase_len / 2 && $urandom_range(0, 1) == 1)
          write_reg(CFG_POLICY, 4'($urandom));
        if ($urandom_range(0, 99) < 45) add_job(8'($urandom), rand_length());
        else tick($urandom_range(0, 5) == 0);
      end
      drain();
      steady = 1'b0;
    end

    settle();
    $display("Covered %0d command beats (%0d adds, %0d ticks) over %0d policy writes.",
             n_items, n_adds, n_ticks, n_settings);
    $display("Checked %0d result beats, %0d mismatching.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASS multi_policy_process_scheduler");
    end else begin
      $display("FAIL multi_policy_process_scheduler");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #20ms;
    $display("Timeout with %0d result beats outstanding.", sb.expected_q.size());
    $display("FAIL multi_policy_process_scheduler");
    $finish;
  end

endmodule
`default_nettype wire

[multi_policy_process_scheduler.f]
rtl/core/mpps_pkg.sv
rtl/core/mpps_queue.sv
rtl/core/multi_policy_process_scheduler.sv
verif/multi_policy_process_scheduler_tb.sv
